@@ rtl/aes128_ofb_stream_cipher_top_defines.svh @@
// Assertion macros for the cipher controller module.
`ifndef AES128_OFB_STREAM_CIPHER_TOP_DEFINES_SVH
`define AES128_OFB_STREAM_CIPHER_TOP_DEFINES_SVH
`define AOFB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define AOFB_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ rtl/aofb_pkg.sv @@
// Package with the cipher tables, types and helper functions.
`default_nettype none
package aofb_pkg;
  localparam int unsigned BlockW = 128;
  localparam int unsigned KeyStoreDepth = 11;
  localparam int unsigned KeyIdxW = 4;

  typedef enum logic [1:0] {
    CfgKeyHi = 2'd0,
    CfgKeyLo = 2'd1,
    CfgIvHi  = 2'd2,
    CfgIvLo  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StExpand,
    StLoad,
    StRound,
    StOut
  } state_e;

  typedef struct packed {
    logic          exp_start;
    logic          exp_step;
    logic          load;
    logic          restart;
    logic          round;
    logic          last;
    logic          out_load;
    logic [KeyIdxW-1:0] key_idx;
  } cmd_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [KeyIdxW-1:0] r);
    logic [7:0] v;
    case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

@@ rtl/aofb_ram.sv @@
// Generic RAM with one write port and one registered read port.
`default_nettype none
module aofb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ rtl/aofb_ctrl.sv @@
// Controller state machine sequencing key expansion and cipher rounds.
`default_nettype none
`include "aes128_ofb_stream_cipher_top_defines.svh"
module aofb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire logic          in_restart_i,
  output      logic          out_valid_o,
  input  wire logic          out_ready_i,
  input  wire logic          key_write_i,
  output      aofb_pkg::cmd_t cmd_o
);
  aofb_pkg::state_e state_q, state_d;
  logic [aofb_pkg::KeyIdxW-1:0] cnt_q, cnt_d;
  logic keys_ready_q, keys_ready_d;
  logic restart_q, restart_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= aofb_pkg::StIdle;
      cnt_q        <= '0;
      keys_ready_q <= 1'b0;
      restart_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      keys_ready_q <= keys_ready_d;
      restart_q    <= restart_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    keys_ready_d = keys_ready_q;
    restart_d    = restart_q;
    cmd_o        = '0;
    cmd_o.key_idx = cnt_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    case (state_q)
      aofb_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          restart_d = in_restart_i;
          cnt_d = '0;
          if (keys_ready_q) begin
            cmd_o.key_idx = '0;
            state_d = aofb_pkg::StLoad;
          end else begin
            cmd_o.exp_start = 1'b1;
            state_d = aofb_pkg::StExpand;
          end
        end
      end
      aofb_pkg::StExpand: begin
        cmd_o.exp_step = 1'b1;
        if (cnt_q == aofb_pkg::KeyIdxW'(aofb_pkg::KeyStoreDepth - 1)) begin
          keys_ready_d = 1'b1;
          cnt_d = '0;
          cmd_o.key_idx = '0;
          state_d = aofb_pkg::StLoad;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      aofb_pkg::StLoad: begin
        cmd_o.load = 1'b1;
        cmd_o.restart = restart_q;
        cnt_d = cnt_q + 1'b1;
        cmd_o.key_idx = cnt_q + 1'b1;
        state_d = aofb_pkg::StRound;
      end
      aofb_pkg::StRound: begin
        cmd_o.round = 1'b1;
        cmd_o.last = (cnt_q == aofb_pkg::KeyIdxW'(aofb_pkg::KeyStoreDepth - 1));
        if (cmd_o.last) begin
          cmd_o.out_load = 1'b1;
          state_d = aofb_pkg::StOut;
        end else begin
          cnt_d = cnt_q + 1'b1;
          cmd_o.key_idx = cnt_q + 1'b1;
        end
      end
      aofb_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = aofb_pkg::StIdle;
        end
      end
      default: state_d = aofb_pkg::StIdle;
    endcase
    if (key_write_i) begin
      keys_ready_d = 1'b0;
    end
  end

  `AOFB_ASSERT(a_out_only_after_round, clk_i, rst_ni,
    out_valid_o && !$past(out_valid_o) |-> $past(state_q == aofb_pkg::StRound),
    "result shown without a finished last round")
  `AOFB_ASSERT(a_load_needs_keys, clk_i, rst_ni,
    state_q == aofb_pkg::StLoad |-> keys_ready_q || $past(key_write_i),
    "cipher started with a stale key schedule")
  `AOFB_ASSERT(a_round_count, clk_i, rst_ni,
    state_q == aofb_pkg::StRound |-> cnt_q != '0,
    "round counter out of range")
endmodule
`default_nettype wire

@@ rtl/aofb_datapath.sv @@
// Datapath: key schedule, round key store, round unit and feedback.
`default_nettype none
module aofb_datapath (
  input  wire logic           clk_i,
  input  wire aofb_pkg::cmd_t cmd_i,
  input  wire logic [127:0]   key_i,
  input  wire logic [127:0]   iv_i,
  input  wire logic [63:0]    data_hi_i,
  input  wire logic [63:0]    data_lo_i,
  input  wire logic           in_xfer_i,
  input  wire logic           rst_ni,
  output      logic [63:0]    out_hi_o,
  output      logic [63:0]    out_lo_o
);
  logic [127:0] rk_q, rk_d;
  logic [127:0] st_q, st_d;
  logic [127:0] fb_q;
  logic [127:0] data_q;
  logic [127:0] out_q;
  logic [127:0] rk_rd;
  logic [127:0] sr;
  logic [127:0] mc;
  logic [127:0] rnd;
  logic [31:0]  tw;
  logic [aofb_pkg::KeyIdxW-1:0] rcnt_q;

  function automatic logic [7:0] byte_of(input logic [127:0] v, input int n);
    return v[127-8*n -: 8];
  endfunction

  aofb_ram #(.Width(128), .Depth(aofb_pkg::KeyStoreDepth)) u_rk_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.exp_step),
    .waddr_i(rcnt_q),
    .wdata_i(rk_q),
    .raddr_i(cmd_i.key_idx),
    .rdata_o(rk_rd)
  );

  always_comb begin
    tw = {aofb_pkg::sbox(rk_q[23:16]), aofb_pkg::sbox(rk_q[15:8]),
          aofb_pkg::sbox(rk_q[7:0]), aofb_pkg::sbox(rk_q[31:24])};
    tw[31:24] = tw[31:24] ^ aofb_pkg::rcon(rcnt_q + 1'b1);
    rk_d[127:96] = rk_q[127:96] ^ tw;
    rk_d[95:64]  = rk_q[95:64] ^ rk_d[127:96];
    rk_d[63:32]  = rk_q[63:32] ^ rk_d[95:64];
    rk_d[31:0]   = rk_q[31:0] ^ rk_d[63:32];
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[127-8*(4*c+r) -: 8] = aofb_pkg::sbox(byte_of(st_q, 4*((c+r)%4)+r));
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = byte_of(sr, 4*c);
      a1 = byte_of(sr, 4*c+1);
      a2 = byte_of(sr, 4*c+2);
      a3 = byte_of(sr, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[127-8*(4*c)   -: 8] = a0 ^ al ^ aofb_pkg::xtime(a0 ^ a1);
      mc[127-8*(4*c+1) -: 8] = a1 ^ al ^ aofb_pkg::xtime(a1 ^ a2);
      mc[127-8*(4*c+2) -: 8] = a2 ^ al ^ aofb_pkg::xtime(a2 ^ a3);
      mc[127-8*(4*c+3) -: 8] = a3 ^ al ^ aofb_pkg::xtime(a3 ^ a0);
    end
    rnd = (cmd_i.last ? sr : mc) ^ rk_rd;
    st_d = st_q;
    if (cmd_i.load) begin
      st_d = (cmd_i.restart ? iv_i : fb_q) ^ rk_rd;
    end else if (cmd_i.round) begin
      st_d = rnd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q <= '0;
    end else if (cmd_i.out_load) begin
      fb_q <= rnd;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    if (in_xfer_i) begin
      data_q <= {data_hi_i, data_lo_i};
    end
    if (cmd_i.out_load) begin
      out_q <= data_q ^ rnd;
    end
    if (cmd_i.exp_start) begin
      rk_q   <= key_i;
      rcnt_q <= '0;
    end else if (cmd_i.exp_step) begin
      rk_q   <= rk_d;
      rcnt_q <= rcnt_q + 1'b1;
    end
  end

  assign out_hi_o = out_q[127:64];
  assign out_lo_o = out_q[63:0];
endmodule
`default_nettype wire

@@ rtl/aes128_ofb_stream_cipher_top.sv @@
// Top level of the AES-128 output-feedback stream cipher.
// Each accepted 128-bit block is XORed with the next AES-128 keystream block;
// a set restart bit first reloads the feedback from the IV. A block passes
// from transfer through one load with the first key addition, ten rounds
// on a single round unit and an output state; the first block after reset
// or after a key write is preceded by key expansion into the round key RAM.
// The round key RAM port feeds the rounds one round key a cycle.
`default_nettype none
module aes128_ofb_stream_cipher_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic        restart_i,
  input  wire logic [63:0] data_hi_i,
  input  wire logic [63:0] data_lo_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [63:0] out_hi_o,
  output      logic [63:0] out_lo_o
);
  logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic cfg_xfer, key_write;
  aofb_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer = cfg_valid_i;
  assign key_write = cfg_xfer &&
    (cfg_index_i == aofb_pkg::CfgKeyHi || cfg_index_i == aofb_pkg::CfgKeyLo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      iv_hi_q  <= '0;
      iv_lo_q  <= '0;
    end else if (cfg_xfer) begin
      case (cfg_index_i)
        aofb_pkg::CfgKeyHi: key_hi_q <= cfg_data_i;
        aofb_pkg::CfgKeyLo: key_lo_q <= cfg_data_i;
        aofb_pkg::CfgIvHi:  iv_hi_q  <= cfg_data_i;
        aofb_pkg::CfgIvLo:  iv_lo_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aofb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_restart_i(restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .key_write_i (key_write),
    .cmd_o       (cmd)
  );

  aofb_datapath u_dp (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .key_i    ({key_hi_q, key_lo_q}),
    .iv_i     ({iv_hi_q, iv_lo_q}),
    .data_hi_i(data_hi_i),
    .data_lo_i(data_lo_i),
    .in_xfer_i(in_valid_i && in_ready_o),
    .rst_ni   (rst_ni),
    .out_hi_o (out_hi_o),
    .out_lo_o (out_lo_o)
  );
endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Testbench for the AES-128 OFB stream cipher with random stimulus and a keystream predictor.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        restart;
    logic [63:0] hi;
    logic [63:0] lo;
  } blk_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } res_t;

  localparam logic [7:0] SUBST [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };
  localparam logic [7:0] RCON [10] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = aofb_pkg::CfgKeyHi;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        restart_i = 1'b0;
  logic [63:0] data_hi_i = '0;
  logic [63:0] data_lo_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] out_hi_o;
  logic [63:0] out_lo_o;

  aes128_ofb_stream_cipher_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  blk_t        pending_blocks[$];
  res_t        expected_outputs[$];
  logic [127:0] key_reg, iv_reg, feedback;
  logic [127:0] sched_keys [11];
  int          send_idle_pct, stall_pct;
  int          hold_left;
  logic        hold_go = 1'b0;
  logic        in_taken;
  bit          failed;

  function automatic logic [7:0] dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic void expand_round_keys();
    logic [31:0] w [44];
    logic [31:0] t;
    for (int i = 0; i < 4; i++) w[i] = key_reg[127 - 32 * i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i - 1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {SUBST[t[31:24]], SUBST[t[23:16]], SUBST[t[15:8]], SUBST[t[7:0]]};
        t[31:24] ^= RCON[i / 4 - 1];
      end
      w[i] = w[i - 4] ^ t;
    end
    for (int r = 0; r < 11; r++)
      sched_keys[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
  endfunction

  function automatic logic [127:0] encipher_block(input logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] v;
    v = blk ^ sched_keys[0];
    for (int n = 0; n < 16; n++) s[n] = v[127 - 8 * n -: 8];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[4 * c + r] = SUBST[s[4 * ((c + r) & 3) + r]];
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
        all = a0 ^ a1 ^ a2 ^ a3;
        if (rnd < 10) begin
          s[4 * c]     = a0 ^ all ^ dbl(a0 ^ a1);
          s[4 * c + 1] = a1 ^ all ^ dbl(a1 ^ a2);
          s[4 * c + 2] = a2 ^ all ^ dbl(a2 ^ a3);
          s[4 * c + 3] = a3 ^ all ^ dbl(a3 ^ a0);
        end else begin
          s[4 * c] = a0; s[4 * c + 1] = a1; s[4 * c + 2] = a2; s[4 * c + 3] = a3;
        end
      end
      for (int n = 0; n < 16; n++) v[127 - 8 * n -: 8] = s[n];
      v ^= sched_keys[rnd];
      for (int n = 0; n < 16; n++) s[n] = v[127 - 8 * n -: 8];
    end
    return v;
  endfunction

  // The block's result for one transfer; also advances the feedback.
  function automatic res_t next_keystream_xor(input blk_t b);
    res_t r;
    if (b.restart) feedback = iv_reg;
    feedback = encipher_block(feedback);
    r.hi = b.hi ^ feedback[127:64];
    r.lo = b.lo ^ feedback[63:0];
    return r;
  endfunction

  function automatic void add_block(input logic rs, input logic [63:0] hi,
                                    input logic [63:0] lo);
    blk_t b;
    b.restart = rs;
    b.hi = hi;
    b.lo = lo;
    pending_blocks.insert(pending_blocks.size(), b);
  endfunction

  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o)
      expected_outputs.insert(expected_outputs.size(),
        next_keystream_xor('{restart_i, data_hi_i, data_lo_i}));
  end

  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (rst_ni && pending_blocks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        restart_i  <= pending_blocks[0].restart;
        data_hi_i  <= pending_blocks[0].hi;
        data_lo_i  <= pending_blocks[0].lo;
        void'(pending_blocks.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (hold_go) hold_left <= 400;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i) begin
    res_t e;
    if (out_valid_o && out_ready_i) begin
      if (expected_outputs.size() == 0) begin
        $display("%0t: unexpected result hi=%h lo=%h", $time, out_hi_o, out_lo_o);
        failed = 1'b1;
      end else begin
        e = expected_outputs.pop_front();
        if (out_hi_o !== e.hi) begin
          $display("%0t: out_hi expected %h actual %h", $time, e.hi, out_hi_o);
          failed = 1'b1;
        end
        if (out_lo_o !== e.lo) begin
          $display("%0t: out_lo expected %h actual %h", $time, e.lo, out_lo_o);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic write_reg(input aofb_pkg::cfg_idx_e idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      aofb_pkg::CfgKeyHi: key_reg[127:64] = val;
      aofb_pkg::CfgKeyLo: key_reg[63:0] = val;
      aofb_pkg::CfgIvHi:  iv_reg[127:64] = val;
      aofb_pkg::CfgIvLo:  iv_reg[63:0] = val;
      default: ;
    endcase
    expand_round_keys();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(input logic [63:0] k1, k0, v1, v0);
    write_reg(aofb_pkg::CfgKeyHi, k1);
    write_reg(aofb_pkg::CfgKeyLo, k0);
    write_reg(aofb_pkg::CfgIvHi, v1);
    write_reg(aofb_pkg::CfgIvLo, v0);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++)
      add_block(($urandom_range(7) == 0), rnd64(), rnd64());
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_blocks.size() != 0 || in_valid_i || expected_outputs.size() != 0);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    key_reg = '0;
    iv_reg = '0;
    feedback = '0;
    failed = 1'b0;
    hold_left = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    expand_round_keys();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset key and IV of zero, data extremes and restart on and off.
    add_block(1'b0, '0, '0);
    add_block(1'b0, '1, '1);
    add_block(1'b1, '0, '0);
    add_block(1'b1, '1, '0);
    add_block(1'b0, '0, '1);
    add_block(1'b0, 64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef);
    drain();

    // A key change keeps the feedback; a new IV waits for the next restart.
    write_reg(aofb_pkg::CfgKeyHi, '1);
    add_block(1'b0, '0, '0);
    drain();
    write_reg(aofb_pkg::CfgKeyLo, '1);
    write_reg(aofb_pkg::CfgIvHi, '1);
    write_reg(aofb_pkg::CfgIvLo, '1);
    add_block(1'b0, '1, '1);
    add_block(1'b1, '0, '0);
    add_block(1'b0, '0, '0);
    drain();
    write_all(64'h2b7e_1516_28ae_d2a6, 64'habf7_1588_09cf_4f3c,
              64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f);
    add_block(1'b1, 64'h6bc1_bee2_2e40_9f96, 64'he93d_7e11_7393_172a);
    add_block(1'b0, 64'hae2d_8a57_1e03_ac9c, 64'h9eb7_6fac_45af_8e51);
    add_block(1'b1, '1, '1);
    drain();

    write_all(rnd64(), rnd64(), rnd64(), rnd64());
    send_idle_pct = 77;
    queue_random(190);
    drain();

    write_all('1, '1, '1, '1);
    send_idle_pct = 0;
    stall_pct = 77;
    queue_random(190);
    @(negedge clk_i);
    hold_go <= 1'b1;
    @(negedge clk_i);
    hold_go <= 1'b0;
    drain();

    write_all(rnd64(), rnd64(), rnd64(), rnd64());
    send_idle_pct = 15;
    stall_pct = 15;
    queue_random(190);
    drain();

    write_all('0, '0, rnd64(), rnd64());
    send_idle_pct = 0;
    stall_pct = 0;
    queue_random(190);
    drain();

    if (!failed) begin
      $display("** aes128_ofb_stream_cipher_top: PASSED **");
    end else begin
      $display("** aes128_ofb_stream_cipher_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("** aes128_ofb_stream_cipher_top: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/aofb_pkg.sv
rtl/aofb_ram.sv
rtl/aofb_ctrl.sv
rtl/aofb_datapath.sv
rtl/aes128_ofb_stream_cipher_top.sv
verif/testbench.sv
